// ----- rtl/bss_pkg.sv -----
// Shared types and the run-limit constant for the bit-stuffing serializer.
package bss_pkg;

	localparam logic [2:0] RUN_LIMIT = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic line_bit;
		logic stuffed;
		logic run_end;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic emit_lead;
		logic emit_data;
		logic emit_stuff;
		logic stuff_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic bit_last;
		logic stuff_need;
		logic first_in;
	} dp_stat_t;

endpackage

// ----- rtl/bit_stuffing_serializer.sv -----
// Top level of the bit-stuffing serializer: sequencer plus datapath.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, in_item      | byte in
//  output  | out_valid, out_ready, out_item   | line bit out
//
// Each byte is taken in the idle state, then sent at one line bit per cycle while
// the output is not stalled: 8 bits, 9 for a first byte, up to 10 for a middle
// byte with stuffing.
// The bit sequencer is the limit; in_ready is high only while it is idle.
// A stalled output register holds the sequencer in place.
// Reset clears the sequencer, the ones run and the output valid flag.
module bit_stuffing_serializer
	import bss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/bss_ctrl.sv -----
// Sequencer for the bit-stuffing serializer: lead bit, data bits, stuffed zeros.
module bss_ctrl
	import bss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_LEAD      = 3'd1;
	localparam logic [2:0] ST_DATA      = 3'd2;
	localparam logic [2:0] ST_STUFF_MID = 3'd3;
	localparam logic [2:0] ST_STUFF_END = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = stat.first_in ? ST_LEAD : ST_DATA;
				end
			end
			ST_LEAD: begin
				if (stat.out_free) begin
					cmd.emit_lead = 1'b1;
					state_next    = ST_DATA;
				end
			end
			ST_DATA: begin
				if (stat.out_free) begin
					cmd.emit_data = 1'b1;
					if (stat.stuff_need) begin
						state_next = stat.bit_last ? ST_STUFF_END : ST_STUFF_MID;
					end else if (stat.bit_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			ST_STUFF_MID: begin
				if (stat.out_free) begin
					cmd.emit_stuff = 1'b1;
					state_next     = ST_DATA;
				end
			end
			ST_STUFF_END: begin
				if (stat.out_free) begin
					cmd.emit_stuff = 1'b1;
					cmd.stuff_last = 1'b1;
					state_next     = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

`ifndef SYNTHESIS
	a_stuff_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STUFF_MID || state_q == ST_STUFF_END) |->
		($past(state_q) == ST_DATA || $past(state_q) == state_q))
		else $error("stuff state not entered from data state");

	a_lead_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && stat.first_in) |=> (state_q == ST_LEAD))
		else $error("first item did not start with lead bit");
`endif

endmodule

// ----- rtl/bss_dp.sv -----
// Datapath: byte shifter, bit counter, ones-run counter and output register.
module bss_dp
	import bss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	logic [7:0] data_q;
	logic [2:0] cnt_q;
	logic       middle_q;
	logic [2:0] ones_run_q;
	out_item_t  out_q;
	logic       out_valid_q;

	logic [2:0] run_inc;
	logic       emit;

	assign run_inc = data_q[7] ? ones_run_q + 3'd1 : 3'd0;
	assign emit    = cmd.emit_lead | cmd.emit_data | cmd.emit_stuff;

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.bit_last   = (cnt_q == 3'd7);
	assign stat.stuff_need = middle_q && (run_inc == RUN_LIMIT);
	assign stat.first_in   = in_item.first_byte;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			middle_q    <= 1'b0;
			ones_run_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				cnt_q    <= '0;
				middle_q <= !in_item.first_byte && !in_item.final_byte;
				if (in_item.first_byte) begin
					ones_run_q <= '0;
				end
			end else if (cmd.emit_data) begin
				cnt_q <= cnt_q + 3'd1;
				if (middle_q) begin
					ones_run_q <= stat.stuff_need ? 3'd0 : run_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= in_item.data_byte;
		end else if (cmd.emit_data) begin
			data_q <= {data_q[6:0], 1'b0};
		end
		if (cmd.emit_lead) begin
			out_q <= '{line_bit: 1'b1, stuffed: 1'b0, run_end: 1'b0};
		end else if (cmd.emit_data) begin
			out_q <= '{line_bit: data_q[7], stuffed: 1'b0,
				run_end: stat.bit_last && !stat.stuff_need};
		end else if (cmd.emit_stuff) begin
			out_q <= '{line_bit: 1'b0, stuffed: 1'b1, run_end: cmd.stuff_last};
		end
	end

`ifndef SYNTHESIS
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_run_q <= 3'd4)
		else $error("ones run exceeded four");

	a_stuff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.stuffed) |-> !out_q.line_bit)
		else $error("stuffed bit is not zero");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the bit-stuffing serializer: random and directed bytes.
module testbench;
	import bss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	class line_bit_board;
		out_item_t  expected_bits[$];
		logic [2:0] ones_run;
		int         mismatches;
		int         bits_checked;
		int         stuffs_checked;

		function new();
			ones_run = '0;
			mismatches = 0;
			bits_checked = 0;
			stuffs_checked = 0;
		endfunction

		function void push_bit(logic b, logic s);
			out_item_t e;
			e.line_bit = b;
			e.stuffed  = s;
			e.run_end  = 1'b0;
			expected_bits.push_back(e);
		endfunction

		// Expand one accepted byte into its line bits.
		function void note_byte(in_item_t item);
			logic [7:0] shift;
			logic       middle;
			out_item_t  tail;
			middle = !item.first_byte && !item.final_byte;
			shift = item.data_byte;
			if (item.first_byte) begin
				push_bit(1'b1, 1'b0);
				ones_run = '0;
			end
			for (int j = 0; j < 8; j++) begin
				push_bit(shift[7], 1'b0);
				if (middle) begin
					ones_run = shift[7] ? ones_run + 3'd1 : 3'd0;
					if (ones_run == RUN_LIMIT) begin
						ones_run = '0;
						push_bit(1'b0, 1'b1);
					end
				end
				shift = shift << 1;
			end
			tail = expected_bits.pop_back();
			tail.run_end = 1'b1;
			expected_bits.push_back(tail);
		endfunction

		function void check_bit(out_item_t got);
			out_item_t e;
			if (expected_bits.size() == 0) begin
				$error("unexpected line bit: line_bit %0b stuffed %0b run_end %0b",
					got.line_bit, got.stuffed, got.run_end);
				mismatches++;
				return;
			end
			e = expected_bits.pop_front();
			bits_checked++;
			if (got.stuffed)
				stuffs_checked++;
			if (got.line_bit !== e.line_bit) begin
				$error("line_bit mismatch: expected %0b, got %0b",
					e.line_bit, got.line_bit);
				mismatches++;
			end
			if (got.stuffed !== e.stuffed) begin
				$error("stuffed mismatch: expected %0b, got %0b",
					e.stuffed, got.stuffed);
				mismatches++;
			end
			if (got.run_end !== e.run_end) begin
				$error("run_end mismatch: expected %0b, got %0b",
					e.run_end, got.run_end);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	line_bit_board board = new();
	int sender_idle_pct;
	int receiver_stall_pct;
	int bytes_sent;

	bit_stuffing_serializer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: check accepted bits, then pick the next ready level.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.check_bit(out_item);
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic in_item_t make_byte(logic [7:0] d, logic f, logic l);
		in_item_t item;
		item.data_byte  = d;
		item.first_byte = f;
		item.final_byte = l;
		return item;
	endfunction

	task automatic send_byte(in_item_t item);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_byte(item);
		bytes_sent++;
	endtask

	task automatic drain_bits();
		in_valid <= 1'b0;
		while (board.expected_bits.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed packets, biased toward long runs of ones; some noise.
	task automatic random_phase(int idle_pct, int stall_pct, int count);
		int         sent;
		int         kind;
		int         n_mid;
		logic [7:0] d;
		sent = 0;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		while (sent < count) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				send_byte(make_byte(8'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1))));
				sent++;
			end else begin
				send_byte(make_byte(8'($urandom), 1'b1, $urandom_range(7) == 0));
				sent++;
				n_mid = $urandom_range(6);
				for (int m = 0; m < n_mid; m++) begin
					case ($urandom_range(3))
						0: d = 8'($urandom);
						1: d = 8'hFF;
						default: d = 8'($urandom | $urandom);
					endcase
					send_byte(make_byte(d, 1'b0, 1'b0));
					sent++;
				end
				if (kind != 1) begin
					send_byte(make_byte(8'($urandom), 1'b0, 1'b1));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_item  <= '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		bytes_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: runs across packet boundaries, double stuffing, one-byte packets
		send_byte(make_byte(8'hFF, 1'b0, 1'b0));
		send_byte(make_byte(8'h7F, 1'b0, 1'b0));
		send_byte(make_byte(8'hFF, 1'b1, 1'b0));
		send_byte(make_byte(8'h0F, 1'b0, 1'b0));
		send_byte(make_byte(8'hFF, 1'b0, 1'b0));
		send_byte(make_byte(8'h0F, 1'b0, 1'b0));
		send_byte(make_byte(8'hFF, 1'b0, 1'b1));
		send_byte(make_byte(8'h80, 1'b0, 1'b0));
		send_byte(make_byte(8'hFF, 1'b1, 1'b1));
		send_byte(make_byte(8'h00, 1'b1, 1'b0));
		send_byte(make_byte(8'hAA, 1'b0, 1'b0));
		send_byte(make_byte(8'h55, 1'b0, 1'b0));
		send_byte(make_byte(8'h0F, 1'b0, 1'b0));
		send_byte(make_byte(8'h3C, 1'b1, 1'b0));
		send_byte(make_byte(8'hF8, 1'b0, 1'b0));
		send_byte(make_byte(8'h00, 1'b1, 1'b1));
		send_byte(make_byte(8'h00, 1'b0, 1'b1));
		send_byte(make_byte(8'h1F, 1'b0, 1'b0));
		send_byte(make_byte(8'h01, 1'b0, 1'b0));
		send_byte(make_byte(8'h81, 1'b0, 1'b1));
		drain_bits();

		random_phase(0, 0, 70);
		drain_bits();
		random_phase(72, 0, 70);
		drain_bits();
		random_phase(0, 72, 70);
		drain_bits();
		random_phase(25, 25, 70);
		drain_bits();

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (30) @(posedge clk);
		$display("Sent %0d bytes under four idle/stall mixes; checked %0d line bits, %0d stuffed.",
			bytes_sent, board.bits_checked, board.stuffs_checked);
		if (board.mismatches == 0 && board.expected_bits.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("Timeout with %0d line bits still expected", board.expected_bits.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bss_pkg.sv
rtl/bss_ctrl.sv
rtl/bss_dp.sv
rtl/bit_stuffing_serializer.sv
dv/testbench.sv
